// ===== rtl/csi_pkg.sv =====
// Shared types and constants of the cone/sphere intersection test.
// Holds field widths, register codes and reset values; no dependencies.
`timescale 1ns / 1ps

package csi_pkg;

  // Field widths of an item and of the registers
  localparam int unsigned POS_W    = 32;  // signed Q16.16 positions
  localparam int unsigned AXIS_W   = 17;  // signed Q1.15 axis components
  localparam int unsigned RAD_W    = 31;  // unsigned Q15.16 radius
  localparam int unsigned INV_W    = 24;  // unsigned Q8.16 one over sine
  localparam int unsigned K_W      = 17;  // unsigned Q1.16 cos^2 / sin^2
  localparam int unsigned REG_FRAC = 16;
  localparam int unsigned AXIS_FRAC = 15;
  // aligns e^2 (30 axis fraction bits) with len^2 * k (16 register fraction bits)
  localparam int unsigned ALIGN_SHIFT = 2 * AXIS_FRAC - REG_FRAC;

  // Internal widths, sized so that nothing overflows
  localparam int unsigned CMV_W  = POS_W + 1;             // centre - apex
  localparam int unsigned T_W    = RAD_W + INV_W - REG_FRAC;  // shift distance
  localparam int unsigned OFF_W  = T_W + 1 + AXIS_W - AXIS_FRAC;  // offset component
  localparam int unsigned D_W    = OFF_W + 1;             // shifted centre component
  localparam int unsigned DM_W   = D_W - 1;               // its magnitude
  localparam int unsigned E1_W   = 62;                    // shifted centre along axis
  localparam int unsigned L1_W   = 86;                    // |D|^2
  localparam int unsigned E2_W   = 53;                    // -(C-V).axis
  localparam int unsigned L2_W   = 66;                    // |C-V|^2

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_SINE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COS_SQ   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SIN_SQ   = 2'd2;
  localparam logic [INV_W-1:0] INV_SINE_RST = 24'd131072;
  localparam logic [K_W-1:0]   COS_SQ_RST   = 17'd49152;
  localparam logic [K_W-1:0]   SIN_SQ_RST   = 17'd16384;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 280;
  localparam int unsigned OUT_DATA_W = 8;

  // Pipeline: six geometry stages, three cone test stages
  localparam int unsigned GEOM_STAGES = 6;
  localparam int unsigned TEST_STAGES = 3;
  localparam int unsigned NUM_STAGES  = GEOM_STAGES + TEST_STAGES;

  typedef logic [NUM_STAGES-1:0] stage_en_t;
  typedef logic [TEST_STAGES-1:0] test_en_t;

endpackage

// ===== rtl/cone_sphere_intersection_test.sv =====
// Channel   Direction  Width  Contents
// s_axis    in         280    one cone/sphere query item
// m_axis    out        8      hit flag
// cfg       in         2+24   register index and write data
//
// One item enters per cycle unless a stalled result backs the pipeline up to the input.
// Each item passes through six geometry stages and then the three-stage cone test.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A stalled result holds its stage; earlier stages keep filling until all are full.
// Top level: uses csi_pkg, csi_pipe_ctrl, csi_geom and csi_cone_test.
`timescale 1ns / 1ps

module cone_sphere_intersection_test (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // apex_x, apex_y, apex_z (32 each), axis_x, axis_y, axis_z (17 each),
  // centre_x, centre_y, centre_z (32 each), sphere_radius (31), zero pad
  input  logic [csi_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // hit (1), zero pad
  output logic [csi_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [csi_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [csi_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import csi_pkg::*;

  // Configuration registers
  logic [INV_W-1:0] inv_sine_q;
  logic [K_W-1:0]   cos_sq_q;
  logic [K_W-1:0]   sin_sq_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_sine_q <= INV_SINE_RST;
      cos_sq_q   <= COS_SQ_RST;
      sin_sq_q   <= SIN_SQ_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_INV_SINE: inv_sine_q <= cfg_data_i[INV_W-1:0];
        REG_COS_SQ:   cos_sq_q   <= cfg_data_i[K_W-1:0];
        REG_SIN_SQ:   sin_sq_q   <= cfg_data_i[K_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input item
  logic signed [POS_W-1:0]  apex [3];
  logic signed [AXIS_W-1:0] axis [3];
  logic signed [POS_W-1:0]  centre [3];
  logic [RAD_W-1:0]         radius;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      apex[i]   = s_axis_tdata_i[i*POS_W +: POS_W];
      axis[i]   = s_axis_tdata_i[3*POS_W + i*AXIS_W +: AXIS_W];
      centre[i] = s_axis_tdata_i[3*POS_W + 3*AXIS_W + i*POS_W +: POS_W];
    end
    radius = s_axis_tdata_i[6*POS_W + 3*AXIS_W +: RAD_W];
  end

  // Pipeline control
  stage_en_t stage_en;

  csi_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stage_en_o  (stage_en)
  );

  // Geometry
  logic signed [E1_W-1:0] e;
  logic [L1_W-1:0]        len2;
  logic signed [E2_W-1:0] e2;
  logic [L2_W-1:0]        c2;
  logic                   rge;

  csi_geom u_geom (
    .clk_i      (clk_i),
    .en_i       (stage_en),
    .apex_i     (apex),
    .axis_i     (axis),
    .centre_i   (centre),
    .radius_i   (radius),
    .inv_sine_i (inv_sine_q),
    .e_o        (e),
    .len2_o     (len2),
    .e2_o       (e2),
    .c2_o       (c2),
    .rge_o      (rge)
  );

  // Cone tests: shifted centre against the cone, centre against the back region
  test_en_t test_en;
  logic     in_front;
  logic     in_back;

  assign test_en = stage_en[NUM_STAGES-1:GEOM_STAGES];

  csi_cone_test #(
    .E_W (E1_W),
    .L_W (L1_W)
  ) u_front (
    .clk_i     (clk_i),
    .en_i      (test_en),
    .e_i       (e),
    .len2_i    (len2),
    .k_i       (cos_sq_q),
    .in_cone_o (in_front)
  );

  csi_cone_test #(
    .E_W (E2_W),
    .L_W (L2_W)
  ) u_back (
    .clk_i     (clk_i),
    .en_i      (test_en),
    .e_i       (e2),
    .len2_i    (c2),
    .k_i       (sin_sq_q),
    .in_cone_o (in_back)
  );

  // Carry the radius test alongside the cone tests
  logic [TEST_STAGES-1:0] rge_q;

  always_ff @(posedge clk_i) begin
    if (test_en[0]) begin
      rge_q[0] <= rge;
    end
    for (int k = 1; k < TEST_STAGES; k++) begin
      if (test_en[k]) begin
        rge_q[k] <= rge_q[k-1];
      end
    end
  end

  assign m_axis_tdata_o = {{(OUT_DATA_W-1){1'b0}},
                           in_front & (~in_back | rge_q[TEST_STAGES-1])};

endmodule

// ===== rtl/csi_pipe_ctrl.sv =====
// Valid bits and per-stage load enables of the test pipeline.
// A stage loads when it is empty or its successor loads. Uses csi_pkg.
`timescale 1ns / 1ps

module csi_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output csi_pkg::stage_en_t  stage_en_o
);
  import csi_pkg::*;

  stage_en_t valid_q, valid_d;
  stage_en_t en;

  always_comb begin
    en[NUM_STAGES-1] = ~valid_q[NUM_STAGES-1] | out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = ~valid_q[k] | en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign stage_en_o  = en;

  // Input is refused only when every stage holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q))
    else $error("input stalled with a bubble in the pipeline");

  // Items in flight change only by what enters and leaves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      ($countones(valid_q) == $past($countones(valid_q))
        + ($past(in_valid_i && in_ready_o) ? 1 : 0)
        - ($past(out_valid_o && out_ready_i) ? 1 : 0)))
    else $error("item lost or duplicated in the pipeline");

  // An accepted item lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted item missing from first stage");

endmodule

// ===== rtl/csi_geom.sv =====
// Geometry stages: shifted centre, its axis projection and squared length,
// plus the centre-to-apex terms for the region behind the apex. Uses csi_pkg.
`timescale 1ns / 1ps

module csi_geom (
  input  logic                                 clk_i,
  input  csi_pkg::stage_en_t                   en_i,
  input  logic signed [csi_pkg::POS_W-1:0]     apex_i [3],
  input  logic signed [csi_pkg::AXIS_W-1:0]    axis_i [3],
  input  logic signed [csi_pkg::POS_W-1:0]     centre_i [3],
  input  logic        [csi_pkg::RAD_W-1:0]     radius_i,
  input  logic        [csi_pkg::INV_W-1:0]     inv_sine_i,
  output logic signed [csi_pkg::E1_W-1:0]      e_o,
  output logic        [csi_pkg::L1_W-1:0]      len2_o,
  output logic signed [csi_pkg::E2_W-1:0]      e2_o,
  output logic        [csi_pkg::L2_W-1:0]      c2_o,
  output logic                                 rge_o
);
  import csi_pkg::*;

  localparam int unsigned TP_W  = T_W + 1 + AXIS_W;   // t * axis
  localparam int unsigned CMA_W = CMV_W + AXIS_W;     // cmv * axis
  localparam int unsigned CSQ_W = 2 * CMV_W;          // cmv^2, signed product
  localparam int unsigned R2_W  = 2 * RAD_W;
  localparam int unsigned DE_W  = D_W + AXIS_W;
  localparam int unsigned HALF  = DM_W / 2;
  localparam int unsigned HI_W  = DM_W - HALF;

  // Stage 1: centre - apex, shift distance
  logic [RAD_W+INV_W-1:0]    rprod;
  logic signed [CMV_W-1:0]   cmv1_q [3];
  logic [T_W-1:0]            t1_q;
  logic signed [AXIS_W-1:0]  axis1_q [3];
  logic [RAD_W-1:0]          rad1_q;

  assign rprod = radius_i * inv_sine_i;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        cmv1_q[i]  <= CMV_W'(centre_i[i]) - CMV_W'(apex_i[i]);
        axis1_q[i] <= axis_i[i];
      end
      t1_q   <= rprod[RAD_W+INV_W-1:REG_FRAC];
      rad1_q <= radius_i;
    end
  end

  // Stage 2: offsets along the axis, projections and squares of centre - apex
  logic signed [TP_W-1:0]    toff [3];
  logic signed [CMA_W-1:0]   cma [3];
  logic signed [CSQ_W-1:0]   csq [3];
  logic [R2_W-1:0]           r2;
  logic signed [OFF_W-1:0]   off2_q [3];
  logic signed [CMV_W-1:0]   cmv2_q [3];
  logic signed [AXIS_W-1:0]  axis2_q [3];
  logic signed [CMA_W-1:0]   cma2_q [3];
  logic [CSQ_W-2:0]          csq2_q [3];
  logic [R2_W-1:0]           r2_2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      toff[i] = $signed({1'b0, t1_q}) * axis1_q[i];
      cma[i]  = cmv1_q[i] * axis1_q[i];
      csq[i]  = cmv1_q[i] * cmv1_q[i];
    end
    r2 = rad1_q * rad1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int i = 0; i < 3; i++) begin
        // arithmetic shift floors toward minus infinity
        off2_q[i]  <= toff[i][TP_W-1:AXIS_FRAC];
        cmv2_q[i]  <= cmv1_q[i];
        axis2_q[i] <= axis1_q[i];
        cma2_q[i]  <= cma[i];
        csq2_q[i]  <= csq[i][CSQ_W-2:0];
      end
      r2_2_q <= r2;
    end
  end

  // Stage 3: shifted centre, behind-apex projection, |C-V|^2
  logic signed [D_W-1:0]     dsum [3];
  logic signed [E2_W-1:0]    cma_sum;
  logic [L2_W-1:0]           c2;
  logic signed [D_W-1:0]     d3_q [3];
  logic signed [AXIS_W-1:0]  axis3_q [3];
  logic signed [E2_W-1:0]    e2_3_q;
  logic [L2_W-1:0]           c2_3_q;
  logic [R2_W-1:0]           r2_3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsum[i] = D_W'(cmv2_q[i]) + D_W'(off2_q[i]);
    end
    cma_sum = E2_W'(cma2_q[0]) + E2_W'(cma2_q[1]) + E2_W'(cma2_q[2]);
    c2 = L2_W'(csq2_q[0]) + L2_W'(csq2_q[1]) + L2_W'(csq2_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      d3_q    <= dsum;
      axis3_q <= axis2_q;
      e2_3_q  <= -cma_sum;
      c2_3_q  <= c2;
      r2_3_q  <= r2_2_q;
    end
  end

  // Stage 4: shifted centre times axis, magnitudes for squaring
  logic signed [DE_W-1:0]    de [3];
  logic signed [D_W-1:0]     dneg [3];
  logic [DM_W-1:0]           dm [3];
  logic signed [DE_W-1:0]    de4_q [3];
  logic [DM_W-1:0]           dm4_q [3];
  logic signed [E2_W-1:0]    e2_4_q;
  logic [L2_W-1:0]           c2_4_q;
  logic [R2_W-1:0]           r2_4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      de[i]   = d3_q[i] * axis3_q[i];
      dneg[i] = -d3_q[i];
      dm[i]   = d3_q[i][D_W-1] ? dneg[i][DM_W-1:0] : d3_q[i][DM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      de4_q  <= de;
      dm4_q  <= dm;
      e2_4_q <= e2_3_q;
      c2_4_q <= c2_3_q;
      r2_4_q <= r2_3_q;
    end
  end

  // Stage 5: projection sum, partial products of |D|^2, radius test
  logic signed [E1_W-1:0]    e5;
  logic [2*HALF-1:0]         ll [3];
  logic [HALF+HI_W-1:0]      lh [3];
  logic [2*HI_W-1:0]         hh [3];
  logic signed [E1_W-1:0]    e5_q;
  logic [2*HALF-1:0]         ll5_q [3];
  logic [HALF+HI_W-1:0]      lh5_q [3];
  logic [2*HI_W-1:0]         hh5_q [3];
  logic signed [E2_W-1:0]    e2_5_q;
  logic [L2_W-1:0]           c2_5_q;
  logic                      rge5_q;

  always_comb begin
    e5 = E1_W'(de4_q[0]) + E1_W'(de4_q[1]) + E1_W'(de4_q[2]);
    for (int i = 0; i < 3; i++) begin
      ll[i] = dm4_q[i][HALF-1:0] * dm4_q[i][HALF-1:0];
      lh[i] = dm4_q[i][HALF-1:0] * dm4_q[i][DM_W-1:HALF];
      hh[i] = dm4_q[i][DM_W-1:HALF] * dm4_q[i][DM_W-1:HALF];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      e5_q   <= e5;
      ll5_q  <= ll;
      lh5_q  <= lh;
      hh5_q  <= hh;
      e2_5_q <= e2_4_q;
      c2_5_q <= c2_4_q;
      rge5_q <= (L2_W'(r2_4_q) >= c2_4_q);
    end
  end

  // Stage 6: combine partial products into |D|^2
  logic [L1_W-1:0] len2;
  logic signed [E1_W-1:0] e6_q;
  logic [L1_W-1:0]        len6_q;
  logic signed [E2_W-1:0] e2_6_q;
  logic [L2_W-1:0]        c2_6_q;
  logic                   rge6_q;

  always_comb begin
    len2 = '0;
    for (int i = 0; i < 3; i++) begin
      len2 = len2 + (L1_W'(hh5_q[i]) << (2 * HALF)) + (L1_W'(lh5_q[i]) << (HALF + 1))
           + L1_W'(ll5_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      e6_q   <= e5_q;
      len6_q <= len2;
      e2_6_q <= e2_5_q;
      c2_6_q <= c2_5_q;
      rge6_q <= rge5_q;
    end
  end

  assign e_o    = e6_q;
  assign len2_o = len6_q;
  assign e2_o   = e2_6_q;
  assign c2_o   = c2_6_q;
  assign rge_o  = rge6_q;

endmodule

// ===== rtl/csi_cone_test.sv =====
// Three-stage cone membership test: e > 0 and e^2 >= (len2 * k) << ALIGN_SHIFT.
// Wide squares are split at bit 32 into partial products. Uses csi_pkg.
`timescale 1ns / 1ps

module csi_cone_test #(
  parameter int unsigned E_W = csi_pkg::E1_W,
  parameter int unsigned L_W = csi_pkg::L1_W
) (
  input  logic                        clk_i,
  input  csi_pkg::test_en_t           en_i,
  input  logic signed [E_W-1:0]       e_i,
  input  logic        [L_W-1:0]       len2_i,
  input  logic        [csi_pkg::K_W-1:0] k_i,
  output logic                        in_cone_o
);
  import csi_pkg::*;

  localparam int unsigned M_W  = E_W - 1;
  localparam int unsigned LO_W = 32;
  localparam int unsigned HI_W = M_W - LO_W;
  localparam int unsigned P_W  = 2 * M_W;
  localparam int unsigned L_LO = L_W / 2;
  localparam int unsigned L_HI = L_W - L_LO;
  localparam int unsigned R_W  = L_W + K_W + ALIGN_SHIFT;
  localparam int unsigned C_W  = (P_W > R_W) ? P_W : R_W;

  // Stage 1: partial products
  logic [M_W-1:0]          em;
  logic                    pos1_q;
  logic [2*LO_W-1:0]       ll1_q;
  logic [LO_W+HI_W-1:0]    lh1_q;
  logic [2*HI_W-1:0]       hh1_q;
  logic [L_LO+K_W-1:0]     lk0_1_q;
  logic [L_HI+K_W-1:0]     lk1_1_q;

  // only used when e is positive, where these bits are its magnitude
  assign em = e_i[M_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pos1_q  <= ~e_i[E_W-1] & (|em);
      ll1_q   <= em[LO_W-1:0] * em[LO_W-1:0];
      lh1_q   <= em[LO_W-1:0] * em[M_W-1:LO_W];
      hh1_q   <= em[M_W-1:LO_W] * em[M_W-1:LO_W];
      lk0_1_q <= len2_i[L_LO-1:0] * k_i;
      lk1_1_q <= len2_i[L_W-1:L_LO] * k_i;
    end
  end

  // Stage 2: sums
  logic              pos2_q;
  logic [P_W-1:0]    esq2_q;
  logic [R_W-1:0]    rhs2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      pos2_q <= pos1_q;
      esq2_q <= (P_W'(hh1_q) << (2 * LO_W)) + (P_W'(lh1_q) << (LO_W + 1)) + P_W'(ll1_q);
      rhs2_q <= ((R_W'(lk1_1_q) << L_LO) + R_W'(lk0_1_q)) << ALIGN_SHIFT;
    end
  end

  // Stage 3: compare
  logic in3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      in3_q <= pos2_q & (C_W'(esq2_q) >= C_W'(rhs2_q));
    end
  end

  assign in_cone_o = in3_q;

endmodule

// ===== test/tb_cone_sphere_intersection_test.sv =====
// Testbench for cone_sphere_intersection_test: drives query items and register writes,
// predicts each hit flag in a scoreboard class and compares it with the result stream.
// Depends on csi_pkg and the block under test; nothing else.
`timescale 1ns / 1ps

module tb_cone_sphere_intersection_test;
  import csi_pkg::*;

  localparam int WW = 160;                 // wide enough for every product of the test
  localparam int U = 65536;                // 1.0 in Q16.16
  localparam int AX1 = 32768;              // 1.0 in Q1.15
  localparam int DIAG = 18919;             // 1/sqrt(3) in Q1.15
  localparam int PMIN = 32'h8000_0000;
  localparam int PMAX = 32'h7FFF_FFFF;
  localparam int RMAX = 32'h7FFF_FFFF;
  localparam int N_PHASES = 8;
  localparam int RAND_PER_PHASE = 135;

  // Field order matches tdata, apex_x in the lowest bits
  typedef struct packed {
    logic [5:0]         pad;
    logic [RAD_W-1:0]   radius;
    logic signed [31:0] centre_z;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_x;
    logic signed [16:0] axis_z;
    logic signed [16:0] axis_y;
    logic signed [16:0] axis_x;
    logic signed [31:0] apex_z;
    logic signed [31:0] apex_y;
    logic signed [31:0] apex_x;
  } query_t;

  class hit_scoreboard;
    logic [INV_W-1:0] inv_sine;
    logic [K_W-1:0]   cos_sq;
    logic [K_W-1:0]   sin_sq;
    bit               hit_q[$];
    int unsigned      n_queries, n_hits, n_checked, n_errors;

    function new();
      inv_sine = INV_SINE_RST;
      cos_sq   = COS_SQ_RST;
      sin_sq   = SIN_SQ_RST;
    endfunction

    function void load_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_INV_SINE: inv_sine = val;
        REG_COS_SQ:   cos_sq = val[K_W-1:0];
        REG_SIN_SQ:   sin_sq = val[K_W-1:0];
        default: ;
      endcase
    endfunction

    // along > 0 and along^2 >= len2 * k, with k brought to the axis scale
    function bit cone_contains(logic signed [WW-1:0] along, logic signed [WW-1:0] len2,
                               logic [K_W-1:0] k);
      logic signed [WW-1:0] kw;
      kw = WW'(k);
      return along > 0 && along * along >= (len2 * kw) <<< ALIGN_SHIFT;
    endfunction

    function bit predict_hit(query_t q);
      logic signed [WW-1:0] ax [3];
      logic signed [WW-1:0] cmv [3];
      logic signed [WW-1:0] rad, inv_w, shift_len, dc, fwd, back, len_d, len_c;
      int i;
      rad   = WW'(q.radius);
      inv_w = WW'(inv_sine);
      shift_len = (rad * inv_w) >>> REG_FRAC;
      ax[0] = WW'($signed(q.axis_x));
      ax[1] = WW'($signed(q.axis_y));
      ax[2] = WW'($signed(q.axis_z));
      cmv[0] = WW'($signed(q.centre_x)) - WW'($signed(q.apex_x));
      cmv[1] = WW'($signed(q.centre_y)) - WW'($signed(q.apex_y));
      cmv[2] = WW'($signed(q.centre_z)) - WW'($signed(q.apex_z));
      fwd = '0;
      back = '0;
      len_d = '0;
      len_c = '0;
      for (i = 0; i < 3; i++) begin
        // move the apex back along the axis (add t * axis to C - V); arithmetic shift floors
        dc = cmv[i] + ((shift_len * ax[i]) >>> AXIS_FRAC);
        fwd   += dc * ax[i];
        len_d += dc * dc;
        back  -= cmv[i] * ax[i];
        len_c += cmv[i] * cmv[i];
      end
      if (!cone_contains(fwd, len_d, cos_sq))
        return 1'b0;
      // centre behind the apex: only the distance to the apex decides
      if (cone_contains(back, len_c, sin_sq))
        return (rad * rad) >= len_c;
      return 1'b1;
    endfunction

    function void note_query(query_t q);
      bit h;
      h = predict_hit(q);
      hit_q.push_back(h);
      n_queries++;
      if (h)
        n_hits++;
    endfunction

    function void check_hit(logic actual);
      bit expected;
      if (hit_q.size() == 0) begin
        $display("%0t: hit result with none outstanding: expected none, actual %b",
                 $time, actual);
        n_errors++;
      end else begin
        expected = hit_q.pop_front();
        n_checked++;
        if (actual !== expected) begin
          $display("%0t: hit mismatch: expected %b, actual %b", $time, expected, actual);
          n_errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return hit_q.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  hit_scoreboard sb;
  int unsigned   idle_pct;
  int unsigned   stall_pct;

  cone_sphere_intersection_test dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        sb.load_reg(cfg_addr_i, cfg_data_i);
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_query(s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_hit(m_axis_tdata_o[0]);
    end
  end

  function automatic query_t mk_query(int vx, int vy, int vz, int ax, int ay, int az,
                                      int cx, int cy, int cz, int r);
    query_t q;
    q = '0;
    q.apex_x = vx;
    q.apex_y = vy;
    q.apex_z = vz;
    q.axis_x = ax[16:0];
    q.axis_y = ay[16:0];
    q.axis_z = az[16:0];
    q.centre_x = cx;
    q.centre_y = cy;
    q.centre_z = cz;
    q.radius = r[RAD_W-1:0];
    return q;
  endfunction

  function automatic longint to_fixed(real x, real scale);
    return $rtoi(x * scale + (x < 0.0 ? -0.5 : 0.5));
  endfunction

  // Mostly spheres placed around a random cone, with some pure noise items
  function automatic query_t random_query();
    query_t       q;
    logic [287:0] raw;
    real          dir [3];
    real          side [3];
    real          len, dotp, along, off, rad;
    longint       apx [3];
    longint       ctr [3];
    longint       axi [3];
    int           i, k;
    if ($urandom_range(99) < 15) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
      q = raw[IN_DATA_W-1:0];
      q.pad = '0;
      return q;
    end
    do begin
      for (i = 0; i < 3; i++)
        dir[i] = real'($urandom_range(65536)) - 32768.0;
      len = $sqrt(dir[0] * dir[0] + dir[1] * dir[1] + dir[2] * dir[2]);
    end while (len < 1000.0);
    for (i = 0; i < 3; i++)
      dir[i] = dir[i] / len;
    if ($urandom_range(9) == 0) begin
      k = $urandom_range(2);
      for (i = 0; i < 3; i++)
        dir[i] = 0.0;
      dir[k] = $urandom_range(1) ? 1.0 : -1.0;
    end
    for (i = 0; i < 3; i++)
      side[i] = real'($urandom_range(65536)) - 32768.0;
    dotp = side[0] * dir[0] + side[1] * dir[1] + side[2] * dir[2];
    for (i = 0; i < 3; i++)
      side[i] = side[i] - dotp * dir[i];
    len = $sqrt(side[0] * side[0] + side[1] * side[1] + side[2] * side[2]);
    along = real'($urandom_range(25000)) / 100.0 - 50.0;
    off = (len < 1.0) ? 0.0 : real'($urandom_range(15000)) / 100.0 / len;
    rad = ($urandom_range(19) == 0) ? 0.0 : real'($urandom_range(6000)) / 100.0;
    for (i = 0; i < 3; i++) begin
      apx[i] = longint'($urandom_range(1 << 29)) - (1 << 28);
      axi[i] = to_fixed(dir[i], 32768.0);
      ctr[i] = apx[i] + to_fixed(along * dir[i] + off * side[i], 65536.0);
    end
    q = '0;
    q.apex_x = apx[0][31:0];
    q.apex_y = apx[1][31:0];
    q.apex_z = apx[2][31:0];
    q.axis_x = axi[0][16:0];
    q.axis_y = axi[1][16:0];
    q.axis_z = axi[2][16:0];
    q.centre_x = ctr[0][31:0];
    q.centre_y = ctr[1][31:0];
    q.centre_z = ctr[2][31:0];
    q.radius = RAD_W'(to_fixed(rad, 65536.0));
    return q;
  endfunction

  // Entered and left at a falling edge; valid stays high for a following item
  task automatic send_query(input query_t q);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= q;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0)
      @(negedge clk_i);
    repeat (NUM_STAGES + 4) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic program_angle(input logic [INV_W-1:0] inv, input logic [K_W-1:0] c2,
                               input logic [K_W-1:0] s2);
    cfg_write(REG_INV_SINE, CFG_DATA_W'(inv));
    cfg_write(REG_COS_SQ, CFG_DATA_W'(c2));
    cfg_write(REG_SIN_SQ, CFG_DATA_W'(s2));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int phase;
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_addr_i = REG_INV_SINE;
    cfg_data_i = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed queries under the reset cone (30 degrees)
    send_query(mk_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk_query(0, 0, 0, AX1, 0, 0, 10 * U, 0, 0, U));
    send_query(mk_query(0, 0, 0, AX1, 0, 0, -U, 0, 0, 2 * U));
    send_query(mk_query(0, 0, 0, AX1, 0, 0, -3 * U, 0, 0, 2 * U));
    send_query(mk_query(0, 0, 0, AX1, 0, 0, -2 * U, 0, 0, 2 * U));
    send_query(mk_query(0, 0, 0, AX1, 0, 0, 5 * U, 0, 0, 0));
    send_query(mk_query(0, 0, 0, AX1, 0, 0, 0, 0, 0, 0));
    send_query(mk_query(0, 0, 0, AX1, 0, 0, -U, 0, 0, 0));
    send_query(mk_query(0, 0, 0, AX1, 0, 0, 0, 10 * U, 0, U));
    send_query(mk_query(0, 0, 0, AX1, 0, 0, 0, 10 * U, 0, 9 * U));
    send_query(mk_query(3 * U, -2 * U, U, -AX1, 0, 0, -7 * U, -2 * U, U, U));
    send_query(mk_query(0, 0, 0, 0, AX1, 0, U, 20 * U, -U, 2 * U));
    send_query(mk_query(0, 0, 0, 0, 0, -AX1, 0, U, -8 * U, U));
    send_query(mk_query(0, 0, 0, 65535, 0, 0, 4 * U, 0, 0, U));
    send_query(mk_query(0, 0, 0, -65536, 0, 0, -4 * U, 0, 0, U));
    send_query(mk_query(0, 0, 0, -1, -1, -1, -U, -U, -U, U));
    send_query(mk_query(PMIN, PMIN, PMIN, DIAG, DIAG, DIAG, PMAX, PMAX, PMAX, RMAX));
    send_query(mk_query(PMAX, PMAX, PMAX, DIAG, DIAG, DIAG, PMIN, PMIN, PMIN, RMAX));
    send_query(mk_query(PMAX, PMIN, PMAX, -DIAG, DIAG, -DIAG, PMIN, PMAX, PMIN, 1));
    send_query(mk_query(U, U, U, DIAG, DIAG, DIAG, U, U, U, RMAX));
    send_query(mk_query(PMIN, 0, PMAX, AX1, 0, 0, PMIN, 0, PMAX, 0));

    for (phase = 0; phase < N_PHASES; phase++) begin
      settle();
      case (phase)
        1: program_angle(24'd377407, 17'd63560, 17'd1976);    // 10 degrees
        2: program_angle(24'd75674, 17'd16384, 17'd49152);    // 60 degrees
        3: program_angle(24'd92682, 17'd32768, 17'd32768);    // 45 degrees
        4: program_angle(24'd1877849, 17'd65456, 17'd80);     // 2 degrees
        5: program_angle(24'hFFFFFF, 17'd0, 17'd0);
        6: program_angle(24'd0, 17'h1FFFF, 17'h1FFFF);
        7: program_angle(24'd65536, 17'd0, 17'd65536);        // 90 degrees
        default: ;
      endcase
      case (phase % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 85; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 85; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      repeat (RAND_PER_PHASE) send_query(random_query());
    end
    settle();

    $display("Checked %0d of %0d queries (%0d hits) over %0d cone settings,",
             sb.n_checked, sb.n_queries, sb.n_hits, N_PHASES);
    $display("with register extremes and four sender/receiver idling patterns.");
    if (sb.n_errors == 0 && sb.pending() == 0)
      $display("tb_cone_sphere_intersection_test passed");
    else
      $display("tb_cone_sphere_intersection_test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_cone_sphere_intersection_test failed");
    $finish;
  end

endmodule

// ===== cone_sphere_intersection_test.f =====
rtl/csi_pkg.sv
rtl/csi_pipe_ctrl.sv
rtl/csi_geom.sv
rtl/csi_cone_test.sv
rtl/cone_sphere_intersection_test.sv
test/tb_cone_sphere_intersection_test.sv
